@@ src/f2d_pkg.sv @@
package f2d_pkg;
  localparam int MAX_PRECISION_DEF = 8;
  localparam int ACC_W = 64;
  localparam int BCD_DIGITS = 20;
  localparam int BCD_W = BCD_DIGITS * 4;
  localparam int IDX_W = 5;
  localparam logic [7:0] EXP_ALL_ONES = 8'hff;
  localparam logic [7:0] EXP_BIAS = 8'h7f;
  localparam logic [6:0] CH_MINUS = 7'h2d;
  localparam logic [6:0] CH_DOT = 7'h2e;
  localparam logic [6:0] CH_ZERO = 7'h30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SIGN,
    ST_TEXT,
    ST_INT,
    ST_DOT,
    ST_FRAC
  } state_t;

  function automatic logic [6:0] text_char(input logic [1:0] sel, input logic [2:0] idx);
    logic [6:0] c;
    c = 7'h3f;
    case (sel)
      2'd0: begin
        case (idx)
          3'd0: c = 7'h4e;
          3'd1: c = 7'h61;
          default: c = 7'h4e;
        endcase
      end
      2'd1: begin
        case (idx)
          3'd0: c = 7'h69;
          3'd1: c = 7'h6e;
          default: c = 7'h66;
        endcase
      end
      default: begin
        case (idx)
          3'd0: c = 7'h6f;
          3'd1: c = 7'h76;
          3'd2: c = 7'h65;
          3'd3: c = 7'h72;
          3'd4: c = 7'h66;
          3'd5: c = 7'h6c;
          3'd6: c = 7'h6f;
          default: c = 7'h77;
        endcase
      end
    endcase
    return c;
  endfunction
endpackage

@@ src/f2d_dabble.sv @@
module f2d_dabble (
  input  logic clk,
  input  logic load,
  input  logic [f2d_pkg::ACC_W-1:0] bin_in,
  input  logic step,
  output logic [f2d_pkg::BCD_W-1:0] bcd
);
  import f2d_pkg::*;
  logic [ACC_W-1:0] bin_r;
  logic [BCD_W-1:0] bcd_r;
  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int d = 0; d < BCD_DIGITS; d++) begin
      adj[d*4 +: 4] = (bcd_r[d*4 +: 4] >= 4'd5) ? bcd_r[d*4 +: 4] + 4'd3 : bcd_r[d*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bin_r <= bin_in;
      bcd_r <= '0;
    end else if (step) begin
      bin_r <= {bin_r[ACC_W-2:0], 1'b0};
      bcd_r <= {adj[BCD_W-2:0], bin_r[ACC_W-1]};
    end
  end

  assign bcd = bcd_r;
endmodule

@@ src/float32_to_decimal_ascii_top.sv @@
// float32_to_decimal_ascii_top: formats a binary32 value as ASCII text.
// Input: pulse start with in_float_bits and in_precision while busy is low.
// The item is taken at that edge and busy rises until the last character
// has gone out.
// Output: one character per cycle on out_character with out_valid high for
// that cycle; out_last marks the final character of the number.
// Sequence: the item is decoded at the accepting edge, then double-dabble
// shifting of the 64-bit integer part (one bit per cycle through a
// 20-digit BCD shifter), then the leading digit is found, then one
// character per cycle, up to 30 characters. Special values (NaN, inf,
// overflow) skip the shift loop.
// Fraction digits come from a times-ten step (shift-and-add) each cycle.
// Reset (synchronous, rst_n low) returns the block to idle with busy low.
// The receiver cannot stall: each character is shown for exactly one cycle.
module float32_to_decimal_ascii_top #(
  parameter int MAX_PRECISION = f2d_pkg::MAX_PRECISION_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [31:0] in_float_bits,
  input  logic [7:0] in_precision,
  output logic out_valid,
  output logic [6:0] out_character,
  output logic out_last
);
  import f2d_pkg::*;

  state_t state_r, state_nxt;
  logic sign_r;
  logic [1:0] tsel_r;
  logic [2:0] tlen_r;
  logic [2:0] tidx_r;
  logic [7:0] prec_r;
  logic [7:0] fcnt_r;
  logic [6:0] scnt_r;
  logic [IDX_W-1:0] didx_r;
  logic [ACC_W-1:0] frac_r;
  logic [ACC_W-1:0] ipart;
  logic [ACC_W-1:0] fpart;
  logic [BCD_W-1:0] bcd;
  logic load, step;
  logic [IDX_W-1:0] top_digit;
  logic [ACC_W+3:0] f10;
  logic [7:0] bexp;
  logic [23:0] mant;
  logic signed [9:0] e;
  logic special, is_text;
  logic [1:0] sel_in;

  assign bexp = in_float_bits[30:23];
  assign mant = (bexp != 8'd0) ? {1'b1, in_float_bits[22:0]} : 24'd0;
  assign e = (bexp != 8'd0) ? $signed({2'b00, bexp}) - $signed({2'b00, EXP_BIAS}) : 10'sd0;

  always_comb begin
    ipart = '0;
    fpart = '0;
    is_text = 1'b0;
    sel_in = 2'd2;
    if (bexp == EXP_ALL_ONES) begin
      is_text = 1'b1;
      sel_in = (in_float_bits[22:0] != 23'd0) ? 2'd0 : 2'd1;
    end else if (e > 10'sd63) begin
      is_text = 1'b1;
    end else if (e >= 10'sd23) begin
      ipart = {40'd0, mant} << (e - 10'sd23);
    end else if (e >= 10'sd0) begin
      ipart = {40'd0, mant} >> (10'sd23 - e);
      fpart = ({40'd0, mant} & ((64'd1 << (10'sd23 - e)) - 64'd1)) << (10'sd41 + e);
    end else if (e >= -10'sd40) begin
      fpart = {40'd0, mant} << (10'sd41 + e);
    end
  end
  assign special = is_text;

  assign load = (state_r == ST_IDLE) && start;
  assign step = (state_r == ST_SHIFT) && !scnt_r[6];

  f2d_dabble u_dabble (
    .clk(clk), .load(load), .bin_in(ipart), .step(step), .bcd(bcd)
  );

  always_comb begin
    top_digit = '0;
    for (int d = 1; d < BCD_DIGITS; d++) begin
      if (bcd[d*4 +: 4] != 4'd0) top_digit = IDX_W'(d);
    end
  end

  assign f10 = {frac_r, 3'b000} + {2'b00, frac_r, 1'b0};

  logic text_mode_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = special ? (in_float_bits[31] ? ST_SIGN : ST_TEXT)
                                              : ST_SHIFT;
      ST_SHIFT: if (scnt_r == 7'd64) state_nxt = sign_r ? ST_SIGN : ST_INT;
      ST_SIGN: state_nxt = text_mode_r ? ST_TEXT : ST_INT;
      ST_TEXT: if (tidx_r == tlen_r - 3'd1) state_nxt = ST_IDLE;
      ST_INT: if (didx_r == '0) state_nxt = (prec_r != 8'd0) ? ST_DOT : ST_IDLE;
      ST_DOT: state_nxt = ST_FRAC;
      ST_FRAC: if (fcnt_r == prec_r - 8'd1) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sign_r <= in_float_bits[31];
      tsel_r <= sel_in;
      tlen_r <= is_text ? ((sel_in == 2'd2) ? 3'd0 : 3'd3) : 3'd0;
      tidx_r <= '0;
      prec_r <= (in_precision > 8'(MAX_PRECISION)) ? 8'(MAX_PRECISION) : in_precision;
      frac_r <= fpart;
      scnt_r <= '0;
      fcnt_r <= '0;
    end else begin
      if (state_r == ST_SHIFT) scnt_r <= scnt_r + 7'd1;
      if (state_r == ST_TEXT) tidx_r <= tidx_r + 3'd1;
      if (state_r == ST_FRAC) begin
        frac_r <= f10[ACC_W-1:0];
        fcnt_r <= fcnt_r + 8'd1;
      end
    end
    if (state_r == ST_SHIFT && scnt_r == 7'd64) didx_r <= top_digit;
    else if (state_r == ST_INT) didx_r <= didx_r - IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (load) text_mode_r <= is_text;
  end

  always_comb begin
    out_valid = 1'b0;
    out_character = CH_ZERO;
    out_last = 1'b0;
    unique case (state_r)
      ST_SIGN: begin
        out_valid = 1'b1;
        out_character = CH_MINUS;
      end
      ST_TEXT: begin
        out_valid = 1'b1;
        out_character = text_char(tsel_r, tidx_r);
        out_last = (tidx_r == ((tsel_r == 2'd2) ? 3'd7 : 3'd2));
      end
      ST_INT: begin
        out_valid = 1'b1;
        out_character = CH_ZERO | {3'b000, bcd[didx_r*4 +: 4]};
        out_last = (didx_r == '0) && (prec_r == 8'd0);
      end
      ST_DOT: begin
        out_valid = 1'b1;
        out_character = CH_DOT;
      end
      ST_FRAC: begin
        out_valid = 1'b1;
        out_character = CH_ZERO | {3'b000, f10[ACC_W+3:ACC_W]};
        out_last = (fcnt_r == prec_r - 8'd1);
      end
      default: ;
    endcase
  end

  // text length for overflow is 8: encode via the state transition
  assign busy = (state_r != ST_IDLE);

  property p_text_end;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_TEXT && out_last) |=> (state_r == ST_IDLE);
  endproperty
  a_text_end: assert property (p_text_end) else $error("text did not end");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");

  a_frac_prec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FRAC) |-> (prec_r != 8'd0 && text_mode_r == 1'b0))
    else $error("fraction out of place");
endmodule
